### hw/rtl/ldin_pkg.sv
// Shared types, constants and fixed-point helpers for the lens undistortion core.
package ldin_pkg;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic [31:0] src_col;
        logic [31:0] src_row;
    } t_in;

    typedef enum logic [1:0] {
        STS_CONVERGED = 2'd0,
        STS_LIMIT     = 2'd1,
        STS_SINGULAR  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] dst_col;
        logic signed [31:0] dst_row;
        logic [6:0]         iterations_used;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
        t_q          k1;
        t_q          k2;
        t_q          p1;
        t_q          p2;
    } t_cfg;

    typedef enum logic [2:0] {
        CFG_FOCAL_X = 3'd0,
        CFG_FOCAL_Y = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_K1 = 3'd4,
        CFG_K2 = 3'd5,
        CFG_P1 = 3'd6,
        CFG_P2 = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NX_GO, ST_NX_WAIT, ST_NY_GO, ST_NY_WAIT, ST_EXEC, ST_WB,
        ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT, ST_UPD, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        U_XX0, U_R20,
        U_E_RR, U_E_K1R, U_E_RAD, U_E_XY, U_E_PXY1, U_E_PXY2, U_E_XX, U_E_YY,
        U_E_P1X, U_E_P1Y, U_E_P2X, U_E_P2Y, U_E_XR, U_E_F1, U_E_YR, U_E_F2,
        U_I_XX, U_I_R2, U_I_DA, U_I_DET, U_I_NXA, U_I_NX, U_I_NYA, U_I_NY,
        U_L_X, U_L_Y, U_O_COL, U_O_ROW
    } t_uop;

    localparam logic [31:0] FOCAL_RESET = 32'd65536000;
    localparam t_q ONE_Q28 = 32'sh1000_0000;
    localparam logic signed [65:0] STEP_LIMIT = 66'sd879609302221;
    localparam int DIV_STEPS = 60;

    function automatic t_q f_sat(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_q f_add(input t_q a, input t_q b);
        return f_sat(40'(a) + 40'(b));
    endfunction

    function automatic t_q f_sub(input t_q a, input t_q b);
        return f_sat(40'(a) - 40'(b));
    endfunction

    function automatic t_q f_dbl(input t_q a);
        return f_add(a, a);
    endfunction

    function automatic logic signed [32:0] f_abs33(input t_q a);
        logic signed [32:0] w;
        w = 33'(a);
        return a[31] ? -w : w;
    endfunction

    function automatic logic signed [32:0] f_s33(input t_q a);
        return 33'(a);
    endfunction

endpackage

### hw/rtl/ldin_front.sv
// Input side: accepts point transactions into a two-entry queue for the solver.
module ldin_front
    import ldin_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_q_valid,
    input  logic i_q_pop,
    output t_in  o_q_data
);

    t_in        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_mem[r_rp];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in;
        end
    end

endmodule

### hw/rtl/ldin_div.sv
// Shared restoring divider: 60-bit magnitude by 32-bit magnitude, saturated signed result.
module ldin_div
    import ldin_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [59:0] i_num,
    input  logic [31:0] i_den,
    input  logic        i_neg,
    output logic        o_done,
    output t_q          o_quot
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [59:0]   r_num;
    logic [59:0]   r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_fin;
    logic [32:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_num[59]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[58:0], 1'b0};
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_q   <= {r_q[58:0], fits};
        end
    end

    assign o_done = r_fin;

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > 60'd2147483647) ? 32'sh7FFF_FFFF : r_q[31:0];
        end else begin
            o_quot = (r_q > 60'd2147483648) ? 32'sh8000_0000 : -r_q[31:0];
        end
    end

endmodule

### hw/rtl/ldin_back.sv
// Solver sequencer: normalisation, Newton iteration with shared multiplier and divider, output register.
module ldin_back
    import ldin_pkg::*;
#(
    parameter int MAX_ITERATIONS = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    output logic o_q_pop,
    input  t_in  i_q_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int CW = $clog2(MAX_ITERATIONS + 1);

    t_state r_state, n_state;
    t_uop   r_uop, n_uop;

    t_in r_src;
    t_q  r_x, r_y, r_x1, r_y1, r_r2, r_rr, r_k1r, r_rad, r_xy, r_pxy1, r_pxy2;
    t_q  r_xx, r_yy, r_p1x, r_p1y, r_p2x, r_p2y, r_tmp, r_f1, r_f2;
    t_q  r_jxx, r_jxy, r_jyx, r_jyy, r_det, r_nx, r_ny, r_dx, r_dy, r_col, r_row;
    logic          r_lx, r_ly, r_init;
    logic [CW-1:0] r_cnt;
    t_status       r_status;
    logic signed [65:0] r_prod;
    logic          r_ov;
    t_out          r_out;

    logic               div_start, div_done, div_neg;
    logic [59:0]        div_num;
    logic [31:0]        div_den;
    t_q                 div_quot;
    logic signed [32:0] mul_a, mul_b;
    t_q                 qm, v_det, v_pix;
    logic               more;
    logic [32:0]        ndiff;
    logic [31:0]        nmag;
    logic [31:0]        ncen, nfoc;
    logic [31:0]        nsrc;
    logic [31:0]        cnt_ext;

    ldin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign qm    = f_sat(40'(r_prod >>> 28));
    assign v_det = f_sub(r_tmp, qm);
    assign v_pix = f_sat(40'(r_prod >>> 28) + $signed({8'd0, (r_uop == U_O_COL) ? i_cfg.cx
                                                                                : i_cfg.cy}));
    assign more  = (r_lx || r_ly) && (r_cnt < CW'(MAX_ITERATIONS));

    // next state
    always_comb begin
        n_state = r_state;
        n_uop   = r_uop;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_NX_GO;
                end
            end
            ST_NX_GO: n_state = ST_NX_WAIT;
            ST_NX_WAIT: begin
                if (div_done) begin
                    n_state = ST_NY_GO;
                end
            end
            ST_NY_GO: n_state = ST_NY_WAIT;
            ST_NY_WAIT: begin
                if (div_done) begin
                    n_state = ST_EXEC;
                    n_uop   = U_XX0;
                end
            end
            ST_EXEC: n_state = ST_WB;
            ST_WB: begin
                n_state = ST_EXEC;
                case (r_uop)
                    U_E_F2: n_uop = (r_init || more) ? U_I_XX : U_O_COL;
                    U_I_DET: n_uop = (v_det == 32'sd0) ? U_O_COL : U_I_NXA;
                    U_I_NY: n_state = ST_DX_GO;
                    U_L_Y: n_uop = U_E_RR;
                    U_O_ROW: n_state = ST_OUT;
                    default: n_uop = t_uop'(r_uop + 5'd1);
                endcase
            end
            ST_DX_GO: n_state = ST_DX_WAIT;
            ST_DX_WAIT: begin
                if (div_done) begin
                    n_state = ST_DY_GO;
                end
            end
            ST_DY_GO: n_state = ST_DY_WAIT;
            ST_DY_WAIT: begin
                if (div_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = ST_EXEC;
                n_uop   = U_L_X;
            end
            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: queue pop, divider operands, multiplier operands
    always_comb begin
        o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 32'd1;
        div_neg   = 1'b0;
        nsrc      = (r_state == ST_NX_GO) ? r_src.src_col : r_src.src_row;
        ncen      = (r_state == ST_NX_GO) ? i_cfg.cx : i_cfg.cy;
        nfoc      = (r_state == ST_NX_GO) ? i_cfg.fx : i_cfg.fy;
        ndiff     = {1'b0, nsrc} - {1'b0, ncen};
        nmag      = ndiff[32] ? 32'(-ndiff) : ndiff[31:0];
        case (r_state)
            ST_NX_GO, ST_NY_GO: begin
                div_start = 1'b1;
                div_num   = {nmag, 28'd0};
                div_den   = (nfoc == 32'd0) ? 32'd1 : nfoc;
                div_neg   = ndiff[32];
            end
            ST_DX_GO, ST_DY_GO: begin
                div_start = 1'b1;
                div_num   = {32'(f_abs33((r_state == ST_DX_GO) ? r_nx : r_ny)), 28'd0};
                div_den   = 32'(f_abs33(r_det));
                div_neg   = ((r_state == ST_DX_GO) ? r_nx[31] : r_ny[31]) ^ r_det[31];
            end
            default: ;
        endcase

        mul_a = f_s33(r_x1);
        mul_b = f_s33(r_x1);
        case (r_uop)
            U_XX0, U_E_XX, U_I_XX: begin
                mul_a = f_s33(r_x1); mul_b = f_s33(r_x1);
            end
            U_R20, U_E_YY, U_I_R2: begin
                mul_a = f_s33(r_y1); mul_b = f_s33(r_y1);
            end
            U_E_RR:   begin mul_a = f_s33(r_r2);     mul_b = f_s33(r_r2);  end
            U_E_K1R:  begin mul_a = f_s33(i_cfg.k1); mul_b = f_s33(r_r2);  end
            U_E_RAD:  begin mul_a = f_s33(i_cfg.k2); mul_b = f_s33(r_rr);  end
            U_E_XY:   begin mul_a = f_s33(r_x1);     mul_b = f_s33(r_y1);  end
            U_E_PXY1: begin mul_a = f_s33(i_cfg.p1); mul_b = f_s33(r_xy);  end
            U_E_PXY2: begin mul_a = f_s33(i_cfg.p2); mul_b = f_s33(r_xy);  end
            U_E_P1X:  begin mul_a = f_s33(i_cfg.p1); mul_b = f_s33(r_x1);  end
            U_E_P1Y:  begin mul_a = f_s33(i_cfg.p1); mul_b = f_s33(r_y1);  end
            U_E_P2X:  begin mul_a = f_s33(i_cfg.p2); mul_b = f_s33(r_x1);  end
            U_E_P2Y:  begin mul_a = f_s33(i_cfg.p2); mul_b = f_s33(r_y1);  end
            U_E_XR:   begin mul_a = f_s33(r_x1);     mul_b = f_s33(r_rad); end
            U_E_F1: begin
                mul_a = f_s33(i_cfg.p2); mul_b = f_s33(f_add(r_r2, f_dbl(r_xx)));
            end
            U_E_YR:   begin mul_a = f_s33(r_y1);     mul_b = f_s33(r_rad); end
            U_E_F2: begin
                mul_a = f_s33(i_cfg.p1); mul_b = f_s33(f_add(r_r2, f_dbl(r_yy)));
            end
            U_I_DA:   begin mul_a = f_s33(r_jxx); mul_b = f_s33(r_jyy); end
            U_I_DET:  begin mul_a = f_s33(r_jxy); mul_b = f_s33(r_jyx); end
            U_I_NXA:  begin mul_a = f_s33(r_jxy); mul_b = f_s33(r_f2);  end
            U_I_NX:   begin mul_a = f_s33(r_jyy); mul_b = f_s33(r_f1);  end
            U_I_NYA:  begin mul_a = f_s33(r_jyx); mul_b = f_s33(r_f1);  end
            U_I_NY:   begin mul_a = f_s33(r_jxx); mul_b = f_s33(r_f2);  end
            U_L_X:    begin mul_a = f_abs33(r_dx); mul_b = $signed({1'b0, i_cfg.fx}); end
            U_L_Y:    begin mul_a = f_abs33(r_dy); mul_b = $signed({1'b0, i_cfg.fy}); end
            U_O_COL:  begin mul_a = $signed({1'b0, i_cfg.fx}); mul_b = f_s33(r_x1); end
            U_O_ROW:  begin mul_a = $signed({1'b0, i_cfg.fy}); mul_b = f_s33(r_y1); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_uop   <= U_XX0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
            if (r_state == ST_OUT && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_src <= i_q_data;
        end
        if (r_state == ST_NX_WAIT && div_done) begin
            r_x  <= div_quot;
            r_x1 <= div_quot;
        end
        if (r_state == ST_NY_WAIT && div_done) begin
            r_y      <= div_quot;
            r_y1     <= div_quot;
            r_init   <= 1'b1;
            r_cnt    <= '0;
            r_status <= STS_LIMIT;
        end
        if (r_state == ST_DX_WAIT && div_done) begin
            r_dx <= div_quot;
        end
        if (r_state == ST_DY_WAIT && div_done) begin
            r_dy <= div_quot;
        end
        if (r_state == ST_UPD) begin
            r_x1 <= f_add(r_x1, r_dx);
            r_y1 <= f_add(r_y1, r_dy);
        end
        if (r_state == ST_EXEC) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == ST_WB) begin
            case (r_uop)
                U_XX0, U_E_XX, U_I_XX: r_xx <= qm;
                U_R20, U_I_R2: r_r2 <= f_add(r_xx, qm);
                U_E_RR:   r_rr <= qm;
                U_E_K1R:  r_k1r <= qm;
                U_E_RAD:  r_rad <= f_add(f_add(ONE_Q28, r_k1r), qm);
                U_E_XY:   r_xy <= qm;
                U_E_PXY1: r_pxy1 <= qm;
                U_E_PXY2: r_pxy2 <= qm;
                U_E_YY:   r_yy <= qm;
                U_E_P1X:  r_p1x <= qm;
                U_E_P1Y:  r_p1y <= qm;
                U_E_P2X:  r_p2x <= qm;
                U_E_P2Y:  r_p2y <= qm;
                U_E_XR:   r_tmp <= f_add(qm, f_dbl(r_pxy1));
                U_E_F1:   r_f1 <= f_sub(f_add(r_tmp, qm), r_x);
                U_E_YR:   r_tmp <= qm;
                U_E_F2: begin
                    r_f2  <= f_sub(f_add(f_add(r_tmp, qm), f_dbl(r_pxy2)), r_y);
                    r_jxx <= f_add(f_add(r_rad, f_dbl(r_p1y)), f_add(f_dbl(r_p2x), f_dbl(r_p2x)));
                    r_jxy <= f_dbl(r_p1x);
                    r_jyx <= f_dbl(r_p2y);
                    r_jyy <= f_add(f_add(r_rad, f_add(f_dbl(r_p1y), f_dbl(r_p1y))),
                                   f_dbl(r_p2x));
                    if (r_init || more) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_init <= 1'b0;
                    end else if (!(r_lx || r_ly)) begin
                        r_status <= STS_CONVERGED;
                    end
                end
                U_I_DA: r_tmp <= qm;
                U_I_DET: begin
                    r_det <= v_det;
                    if (v_det == 32'sd0) begin
                        r_status <= STS_SINGULAR;
                    end
                end
                U_I_NXA, U_I_NYA: r_tmp <= qm;
                U_I_NX:  r_nx <= v_det;
                U_I_NY:  r_ny <= v_det;
                U_L_X:   r_lx <= (r_prod >= STEP_LIMIT);
                U_L_Y:   r_ly <= (r_prod >= STEP_LIMIT);
                U_O_COL: r_col <= v_pix;
                U_O_ROW: r_row <= v_pix;
                default: ;
            endcase
        end
        if (r_state == ST_OUT && (!r_ov || i_out_ready)) begin
            r_out.dst_col         <= r_col;
            r_out.dst_row         <= r_row;
            r_out.iterations_used <= cnt_ext[6:0];
            r_out.status          <= r_status;
        end
    end

    assign cnt_ext     = 32'(r_cnt);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

### hw/rtl/lens_distortion_inverse_newton_core.sv
// Top level: configuration registers, input queue and Newton undistortion solver.
// Each point takes N iteration steps; a singular Jacobian ends the last step early.
// One point at a time; each step uses two divisions in the shared divider and 26
// operations on the shared 33x33 multiplier.
// Reset: synchronous active-low; clears the queue, sequencer and output valid, and loads
// focal lengths of 1000.0 pixels with all other registers zero.
module lens_distortion_inverse_newton_core
    import ldin_pkg::*;
#(
    parameter int MAX_ITERATIONS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    t_cfg r_cfg;
    logic q_valid;
    logic q_pop;
    t_in  q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fx: FOCAL_RESET, fy: FOCAL_RESET, cx: '0, cy: '0,
                       k1: '0, k2: '0, p1: '0, p2: '0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:  r_cfg.fx <= i_cfg_data;
                CFG_FOCAL_Y:  r_cfg.fy <= i_cfg_data;
                CFG_CENTER_X: r_cfg.cx <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.cy <= i_cfg_data;
                CFG_K1:       r_cfg.k1 <= i_cfg_data;
                CFG_K2:       r_cfg.k2 <= i_cfg_data;
                CFG_P1:       r_cfg.p1 <= i_cfg_data;
                CFG_P2:       r_cfg.p2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ldin_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_data   (q_data)
    );

    ldin_back #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/ldin_checker.sv
// Port-level assertions for the undistortion core, bound to the top level.
module ldin_checker
    import ldin_pkg::*;
#(
    parameter int MAX_ITERATIONS = 100
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == STS_LIMIT |->
            o_out.iterations_used == 7'(MAX_ITERATIONS))
        else $error("limit status with wrong step count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.iterations_used) <= MAX_ITERATIONS)
        else $error("step count above limit");

endmodule

bind lens_distortion_inverse_newton_core ldin_checker #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
) u_ldin_checker (.*);

### sim/tb_top.sv
// Testbench for the lens undistortion core: directed and random points checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import ldin_pkg::*;

    localparam int MAX_ITER = 100;
    localparam longint Q28 = 64'sd1 << 28;
    localparam longint unsigned PIX_STEP_LIMIT = 64'd879609302221;
    localparam int STALL_LIMIT = 80000;

    typedef struct {
        longint f1, f2, jxx, jxy, jyx, jyy;
    } t_jac;

    class ldin_board;
        longint fx, fy, cx, cy, k1, k2, p1, p2;
        t_out   pending_q[$];
        int     mismatches;

        function new();
            fx = 65536000; fy = 65536000; cx = 0; cy = 0;
            k1 = 0; k2 = 0; p1 = 0; p2 = 0;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_FOCAL_X:  fx = longint'(v);
                CFG_FOCAL_Y:  fy = longint'(v);
                CFG_CENTER_X: cx = longint'(v);
                CFG_CENTER_Y: cy = longint'(v);
                CFG_K1:       k1 = longint'($signed(v));
                CFG_K2:       k2 = longint'($signed(v));
                CFG_P1:       p1 = longint'($signed(v));
                CFG_P2:       p2 = longint'($signed(v));
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qm(longint a, longint b);
            return sat((a * b) >>> 28);
        endfunction

        function longint qa(longint a, longint b);
            return sat(a + b);
        endfunction

        function t_jac jacobian(longint x1, longint y1, longint r2, longint x, longint y);
            t_jac e;
            longint rad, xy, pxy1, pxy2, xx, yy, p1x, p1y, p2x, p2y, t;
            rad = qa(qa(Q28, qm(k1, r2)), qm(k2, qm(r2, r2)));
            xy = qm(x1, y1);
            pxy1 = qm(p1, xy);
            pxy2 = qm(p2, xy);
            xx = qm(x1, x1);
            yy = qm(y1, y1);
            p1x = qm(p1, x1); p1y = qm(p1, y1);
            p2x = qm(p2, x1); p2y = qm(p2, y1);
            t = qa(qm(x1, rad), qa(pxy1, pxy1));
            t = qa(t, qm(p2, qa(r2, qa(xx, xx))));
            e.f1 = sat(t - x);
            t = qa(qm(y1, rad), qm(p1, qa(r2, qa(yy, yy))));
            t = qa(t, qa(pxy2, pxy2));
            e.f2 = sat(t - y);
            e.jxx = qa(qa(rad, qa(p1y, p1y)), qa(qa(p2x, p2x), qa(p2x, p2x)));
            e.jxy = qa(p1x, p1x);
            e.jyx = qa(p2y, p2y);
            e.jyy = qa(qa(rad, qa(qa(p1y, p1y), qa(p1y, p1y))), qa(p2x, p2x));
            return e;
        endfunction

        function longint norm(logic [31:0] src, longint c, longint f);
            longint diff, dv;
            diff = longint'(src) - c;
            dv = (f != 0) ? f : 1;
            return sat((diff * Q28) / dv);
        endfunction

        function bit big_step(longint d, longint f);
            longint unsigned mag;
            mag = (d < 0) ? -d : d;
            return mag * longint'(f) >= PIX_STEP_LIMIT;
        endfunction

        function t_out undistort(t_in pt);
            t_out   r;
            t_jac   e;
            longint x, y, x1, y1, r2, det, nx, ny, dx, dy;
            int     cnt;
            t_status st;
            bit     big;
            x = norm(pt.src_col, cx, fx);
            y = norm(pt.src_row, cy, fy);
            x1 = x; y1 = y;
            r2 = qa(qm(x1, x1), qm(y1, y1));
            e = jacobian(x1, y1, r2, x, y);
            cnt = 0;
            st = STS_LIMIT;
            do begin
                cnt++;
                r2 = qa(qm(x1, x1), qm(y1, y1));
                det = sat(qm(e.jxx, e.jyy) - qm(e.jxy, e.jyx));
                if (det == 0) begin
                    st = STS_SINGULAR;
                    break;
                end
                nx = sat(qm(e.jxy, e.f2) - qm(e.jyy, e.f1));
                ny = sat(qm(e.jyx, e.f1) - qm(e.jxx, e.f2));
                dx = sat((nx * Q28) / det);
                dy = sat((ny * Q28) / det);
                x1 = qa(x1, dx);
                y1 = qa(y1, dy);
                e = jacobian(x1, y1, r2, x, y);
                big = big_step(dx, fx) || big_step(dy, fy);
                if (!big) st = STS_CONVERGED;
            end while (big && cnt < MAX_ITER);
            r.dst_col = sat(((fx * x1) >>> 28) + cx);
            r.dst_row = sat(((fy * y1) >>> 28) + cy);
            r.iterations_used = cnt[6:0];
            r.status = st;
            return r;
        endfunction

        function void note_point(t_in pt);
            pending_q.push_back(undistort(pt));
        endfunction

        function void check_point(t_out got);
            t_out want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.dst_col !== want.dst_col || got.dst_row !== want.dst_row ||
                got.iterations_used !== want.iterations_used || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp col %h row %h it %0d st %0d, got col %h row %h it %0d st %0d",
                             want.dst_col, want.dst_row, want.iterations_used, want.status,
                             got.dst_col, got.dst_row, got.iterations_used, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;

    ldin_board   sb = new();
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    longint      cycle_cnt = 0;
    longint      last_progress = 0;

    lens_distortion_inverse_newton_core #(.MAX_ITERATIONS(MAX_ITER)) dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt - last_progress > STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side
    initial begin
        t_out got;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
            if (o_out_valid) begin
                got = o_out;
                sb.check_point(got);
                last_progress = cycle_cnt;
            end
        end
    end

    task automatic send_point(logic [31:0] col, logic [31:0] row);
        t_in pt;
        pt.src_col = col;
        pt.src_row = row;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= pt;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_point(pt);
        last_progress = cycle_cnt;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [31:0] v [8]);
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(i);
            i_cfg_data <= v[i];
            sb.set_reg(t_cfg_idx'(i), v[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] px(int p);
        return 32'(p) << 16;
    endfunction

    function automatic logic [31:0] coef(int span);
        return 32'($signed(32'($urandom_range(0, 2 * span))) - span);
    endfunction

    initial begin
        logic [31:0] c [8];
        logic [31:0] ccx, ccy;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: identity lens, saturation at the far corner
        send_point(32'h0, 32'h0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(px(1000), 32'h0);
        send_point(32'h0, px(500));

        // singular Jacobian: radial term vanishes at r2 = 1
        c = '{px(1000), px(1000), 0, 0, 32'hF000_0000, 0, 0, 0};
        write_cfg(c);
        send_point(px(1000), 32'h0);
        send_point(32'h0, px(1000));
        send_point(px(300), px(200));

        // zero focal lengths
        c = '{0, 0, px(100), px(100), 0, 0, 0, 0};
        write_cfg(c);
        send_point(px(100), px(100));
        send_point(px(100) + 1, px(100) - 1);
        send_point(32'hFFFF_FFFF, 32'h0);

        // minimum focal, normalisation overflow
        c = '{32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0};
        write_cfg(c);
        send_point(px(7), px(3));
        send_point(px(9), px(20));
        send_point(32'h8000_0000, 32'h7FFF_FFFF);

        // typical camera
        c = '{px(800), px(820), px(640), px(480), 32'hFB33_3333, 32'h0199_999A,
              32'h0004_1893, 32'hFFFB_E76D};
        write_cfg(c);
        send_point(px(640), px(480));
        send_point(px(0), px(0));
        send_point(px(1280), px(960));

        // register extremes
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_cfg(c);
        send_point(32'h0, 32'h0);
        send_point(32'hFFFF_FFFF, 32'h0);
        c = '{32'h0001_0000, 32'h0001_0000, 0, 0,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        write_cfg(c);
        send_point(px(1), px(1));
        send_point(px(2), 32'h0);

        // all-bits random registers
        for (int i = 0; i < 8; i++) c[i] = $urandom();
        write_cfg(c);
        send_point($urandom(), $urandom());
        send_point($urandom(), $urandom());

        for (int ph = 0; ph < 6; ph++) begin
            ccx = px($urandom_range(900, 1100)) | $urandom_range(0, 16'hFFFF);
            ccy = px($urandom_range(900, 1100)) | $urandom_range(0, 16'hFFFF);
            c = '{px($urandom_range(800, 2000)) | $urandom_range(0, 16'hFFFF),
                  px($urandom_range(800, 2000)) | $urandom_range(0, 16'hFFFF),
                  ccx, ccy, coef(32'h0200_0000), coef(32'h0080_0000),
                  coef(32'h0010_0000), coef(32'h0010_0000)};
            write_cfg(c);
            if (ph == 1) hold_req = 1'b1;
            if (ph == 5) idle_on = 1'b0;
            for (int n = 0; n < 90; n++) begin
                if (ph == 3 && n == 45) drain();
                if ($urandom_range(0, 99) < 3)
                    send_point($urandom(), $urandom());
                else
                    send_point($urandom_range(0, px(2000)), $urandom_range(0, px(2000)));
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
